// ===== src/igmp_pkg.sv =====
package igmp_pkg;

  // Parse position within the message
  typedef enum logic [4:0] {
    PH_IDLE,
    PH_CODE,
    PH_CKSUM,
    PH_GROUP,
    PH_QFLAGS,
    PH_QQIC,
    PH_QNSRC,
    PH_QSRC,
    PH_RESV2,
    PH_NREC,
    PH_RTYPE,
    PH_RAUX,
    PH_RNSRC,
    PH_RGROUP,
    PH_RSRC,
    PH_RAUXW,
    PH_DONE
  } phase_e;

  // Kind of a completed field
  typedef enum logic [3:0] {
    KIND_HEADER,
    KIND_CKSUM,
    KIND_GROUP,
    KIND_QFLAGS,
    KIND_QQIC,
    KIND_NSRC,
    KIND_SOURCE,
    KIND_RESV2,
    KIND_NREC,
    KIND_RTYPE,
    KIND_AUXLEN,
    KIND_RNSRC,
    KIND_RGROUP,
    KIND_AUXWORD
  } kind_e;

  // Message class
  typedef enum logic [2:0] {
    CLS_V1_QUERY,
    CLS_V2_QUERY,
    CLS_V3_QUERY,
    CLS_V1_REPORT,
    CLS_V2_REPORT,
    CLS_LEAVE,
    CLS_V3_REPORT,
    CLS_UNSUPPORTED
  } class_e;

  // IGMP type codes
  localparam logic [7:0] TYPE_QUERY     = 8'h11;
  localparam logic [7:0] TYPE_V1_REPORT = 8'h12;
  localparam logic [7:0] TYPE_V2_REPORT = 8'h16;
  localparam logic [7:0] TYPE_LEAVE     = 8'h17;
  localparam logic [7:0] TYPE_V3_REPORT = 8'h22;

  // Total length that marks a v1/v2 query
  localparam logic [15:0] SHORT_QUERY_LEN = 16'd8;

  // One result word
  typedef struct packed {
    kind_e       kind;
    logic [31:0] value;
    class_e      cls;
    logic [15:0] rec;
    logic [15:0] elem;
    logic        eom;
  } res_t;

  // Bytes in the field of each phase
  function automatic logic [2:0] phase_width(input phase_e ph);
    logic [2:0] w;
    unique case (ph)
      PH_CODE, PH_QFLAGS, PH_QQIC, PH_RTYPE, PH_RAUX:    w = 3'd1;
      PH_CKSUM, PH_QNSRC, PH_RESV2, PH_NREC, PH_RNSRC:   w = 3'd2;
      PH_GROUP, PH_QSRC, PH_RGROUP, PH_RSRC, PH_RAUXW:   w = 3'd4;
      default:                                           w = 3'd0;
    endcase
    return w;
  endfunction

  // Field kind reported in each phase
  function automatic kind_e phase_kind(input phase_e ph);
    kind_e k;
    unique case (ph)
      PH_CKSUM:  k = KIND_CKSUM;
      PH_GROUP:  k = KIND_GROUP;
      PH_QFLAGS: k = KIND_QFLAGS;
      PH_QQIC:   k = KIND_QQIC;
      PH_QNSRC:  k = KIND_NSRC;
      PH_QSRC:   k = KIND_SOURCE;
      PH_RESV2:  k = KIND_RESV2;
      PH_NREC:   k = KIND_NREC;
      PH_RTYPE:  k = KIND_RTYPE;
      PH_RAUX:   k = KIND_AUXLEN;
      PH_RNSRC:  k = KIND_RNSRC;
      PH_RGROUP: k = KIND_RGROUP;
      PH_RSRC:   k = KIND_SOURCE;
      PH_RAUXW:  k = KIND_AUXWORD;
      default:   k = KIND_HEADER;
    endcase
    return k;
  endfunction

endpackage

// ===== src/igmp_in_if.sv =====
// Byte channel into the parser
interface igmp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        first_byte;
  logic [15:0] message_length;

  modport source (output valid, output data_byte, output first_byte,
                  output message_length, input ready);
  modport sink (input valid, input data_byte, input first_byte,
                input message_length, output ready);
endinterface

// ===== src/igmp_out_if.sv =====
// Field channel out of the parser
interface igmp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  field_kind;
  logic [31:0] field_value;
  logic [2:0]  message_class;
  logic [15:0] record_index;
  logic [15:0] element_index;
  logic        end_of_message;

  modport source (output valid, output field_kind, output field_value,
                  output message_class, output record_index,
                  output element_index, output end_of_message, input ready);
  modport sink (input valid, input field_kind, input field_value,
                input message_class, input record_index,
                input element_index, input end_of_message, output ready);
endinterface

// ===== src/igmp_parse.sv =====
// Byte-wide parse state machine: one byte in, at most one field out
module igmp_parse (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         data_byte_i,
  input  logic               first_byte_i,
  input  logic [15:0]        message_length_i,
  output logic               res_valid_o,
  output igmp_pkg::res_t     res_o
);

  igmp_pkg::phase_e phase_q, phase_d;
  logic [1:0]       bif_q, bif_d;
  logic [31:0]      acc_q, acc_d;
  logic [7:0]       type_q, type_d;
  igmp_pkg::class_e cls_q, cls_d;
  logic [15:0]      total_q, total_d;
  logic [15:0]      rcount_q, rcount_d;
  logic [15:0]      rpos_q, rpos_d;
  logic [15:0]      lcount_q, lcount_d;
  logic [15:0]      lpos_q, lpos_d;
  logic [7:0]       aux_q, aux_d;

  logic [15:0] total_dec;
  logic        last;
  logic [31:0] acc_new;
  logic [1:0]  bif_new;
  logic [2:0]  width;
  logic [15:0] rec;
  logic [15:0] elem;
  logic [15:0] lpos_inc;
  logic [15:0] rpos_inc;
  logic        done;

  assign total_dec = total_q - 16'd1;
  assign last      = (total_dec == 16'd0);
  assign acc_new   = {acc_q[23:0], data_byte_i};
  assign bif_new   = bif_q + 2'd1;
  assign width     = igmp_pkg::phase_width(phase_q);
  assign lpos_inc  = lpos_q + 16'd1;
  assign rpos_inc  = rpos_q + 16'd1;
  assign rec       = (phase_q >= igmp_pkg::PH_RTYPE && phase_q != igmp_pkg::PH_DONE)
                     ? rpos_q : 16'd0;
  assign elem      = (phase_q == igmp_pkg::PH_QSRC || phase_q == igmp_pkg::PH_RSRC ||
                      phase_q == igmp_pkg::PH_RAUXW) ? lpos_q : 16'd0;

  // Next state and result word
  always_comb begin
    phase_d     = phase_q;
    bif_d       = bif_q;
    acc_d       = acc_q;
    type_d      = type_q;
    cls_d       = cls_q;
    total_d     = total_q;
    rcount_d    = rcount_q;
    rpos_d      = rpos_q;
    lcount_d    = lcount_q;
    lpos_d      = lpos_q;
    aux_d       = aux_q;
    done        = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (accept_i && first_byte_i) begin
      // Type byte: restart and classify
      bif_d    = '0;
      acc_d    = '0;
      rcount_d = '0;
      rpos_d   = '0;
      lcount_d = '0;
      lpos_d   = '0;
      aux_d    = '0;
      type_d   = data_byte_i;
      unique case (data_byte_i)
        igmp_pkg::TYPE_QUERY:     cls_d = (message_length_i == igmp_pkg::SHORT_QUERY_LEN)
                                          ? igmp_pkg::CLS_V1_QUERY : igmp_pkg::CLS_V3_QUERY;
        igmp_pkg::TYPE_V1_REPORT: cls_d = igmp_pkg::CLS_V1_REPORT;
        igmp_pkg::TYPE_V2_REPORT: cls_d = igmp_pkg::CLS_V2_REPORT;
        igmp_pkg::TYPE_LEAVE:     cls_d = igmp_pkg::CLS_LEAVE;
        igmp_pkg::TYPE_V3_REPORT: cls_d = igmp_pkg::CLS_V3_REPORT;
        default:                  cls_d = igmp_pkg::CLS_UNSUPPORTED;
      endcase
      total_d = (message_length_i == 16'd0) ? 16'd0 : message_length_i - 16'd1;
      if (total_d == 16'd0) begin
        phase_d     = igmp_pkg::PH_DONE;
        res_valid_o = 1'b1;
        res_o.kind  = igmp_pkg::KIND_HEADER;
        res_o.cls   = cls_d;
        res_o.eom   = 1'b1;
      end else begin
        phase_d = igmp_pkg::PH_CODE;
      end
    end else if (accept_i && phase_q != igmp_pkg::PH_IDLE &&
                 phase_q != igmp_pkg::PH_DONE && total_q != 16'd0) begin
      total_d    = total_dec;
      res_o.kind = igmp_pkg::phase_kind(phase_q);
      res_o.rec  = rec;
      res_o.elem = elem;
      if (bif_new != width[1:0]) begin
        // Field still open; close it early if the message runs out
        acc_d = acc_new;
        bif_d = bif_new;
        if (last) begin
          phase_d     = igmp_pkg::PH_DONE;
          res_valid_o = 1'b1;
          res_o.value = acc_new;
          res_o.cls   = cls_q;
          res_o.eom   = 1'b1;
        end
      end else begin
        acc_d = '0;
        bif_d = '0;
        unique case (phase_q)
          igmp_pkg::PH_CODE: begin
            if (type_q == igmp_pkg::TYPE_QUERY && cls_q != igmp_pkg::CLS_V3_QUERY)
              cls_d = (data_byte_i == 8'd0) ? igmp_pkg::CLS_V1_QUERY
                                            : igmp_pkg::CLS_V2_QUERY;
            if (cls_q == igmp_pkg::CLS_UNSUPPORTED) done = 1'b1;
            else phase_d = igmp_pkg::PH_CKSUM;
          end
          igmp_pkg::PH_CKSUM:
            phase_d = (cls_q == igmp_pkg::CLS_V3_REPORT) ? igmp_pkg::PH_RESV2
                                                          : igmp_pkg::PH_GROUP;
          igmp_pkg::PH_GROUP: begin
            if (cls_q == igmp_pkg::CLS_V3_QUERY) phase_d = igmp_pkg::PH_QFLAGS;
            else done = 1'b1;
          end
          igmp_pkg::PH_QFLAGS: phase_d = igmp_pkg::PH_QQIC;
          igmp_pkg::PH_QQIC:   phase_d = igmp_pkg::PH_QNSRC;
          igmp_pkg::PH_QNSRC: begin
            lcount_d = acc_new[15:0];
            lpos_d   = '0;
            if (acc_new[15:0] == 16'd0) done = 1'b1;
            else phase_d = igmp_pkg::PH_QSRC;
          end
          igmp_pkg::PH_QSRC: begin
            lpos_d = lpos_inc;
            if (lpos_inc == lcount_q) done = 1'b1;
          end
          igmp_pkg::PH_RESV2: phase_d = igmp_pkg::PH_NREC;
          igmp_pkg::PH_NREC: begin
            rcount_d = acc_new[15:0];
            rpos_d   = '0;
            if (acc_new[15:0] == 16'd0) done = 1'b1;
            else phase_d = igmp_pkg::PH_RTYPE;
          end
          igmp_pkg::PH_RTYPE: phase_d = igmp_pkg::PH_RAUX;
          igmp_pkg::PH_RAUX: begin
            aux_d   = acc_new[7:0];
            phase_d = igmp_pkg::PH_RNSRC;
          end
          igmp_pkg::PH_RNSRC: begin
            lcount_d = acc_new[15:0];
            phase_d  = igmp_pkg::PH_RGROUP;
          end
          igmp_pkg::PH_RGROUP: begin
            lpos_d = '0;
            if (lcount_q != 16'd0) phase_d = igmp_pkg::PH_RSRC;
            else if (aux_q != 8'd0) phase_d = igmp_pkg::PH_RAUXW;
            else begin
              // End of record
              rpos_d = rpos_inc;
              if (rpos_inc == rcount_q) done = 1'b1;
              else phase_d = igmp_pkg::PH_RTYPE;
            end
          end
          igmp_pkg::PH_RSRC: begin
            lpos_d = lpos_inc;
            if (lpos_inc == lcount_q) begin
              lpos_d = '0;
              if (aux_q != 8'd0) phase_d = igmp_pkg::PH_RAUXW;
              else begin
                rpos_d = rpos_inc;
                if (rpos_inc == rcount_q) done = 1'b1;
                else phase_d = igmp_pkg::PH_RTYPE;
              end
            end
          end
          igmp_pkg::PH_RAUXW: begin
            lpos_d = lpos_inc;
            if (lpos_inc == {8'd0, aux_q}) begin
              lpos_d = '0;
              rpos_d = rpos_inc;
              if (rpos_inc == rcount_q) done = 1'b1;
              else phase_d = igmp_pkg::PH_RTYPE;
            end
          end
          default: done = 1'b1;
        endcase
        if (done || last) phase_d = igmp_pkg::PH_DONE;
        res_valid_o = 1'b1;
        res_o.value = acc_new;
        res_o.cls   = cls_d;
        res_o.eom   = done || last;
      end
    end
  end

  // Parse state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= igmp_pkg::PH_IDLE;
      bif_q    <= '0;
      acc_q    <= '0;
      type_q   <= '0;
      cls_q    <= igmp_pkg::CLS_V1_QUERY;
      total_q  <= '0;
      rcount_q <= '0;
      rpos_q   <= '0;
      lcount_q <= '0;
      lpos_q   <= '0;
      aux_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      bif_q    <= bif_d;
      acc_q    <= acc_d;
      type_q   <= type_d;
      cls_q    <= cls_d;
      total_q  <= total_d;
      rcount_q <= rcount_d;
      rpos_q   <= rpos_d;
      lcount_q <= lcount_d;
      lpos_q   <= lpos_d;
      aux_q    <= aux_d;
    end
  end

endmodule

// ===== src/igmp_outbuf.sv =====
// Result register with a skid slot behind it
module igmp_outbuf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  igmp_pkg::res_t res_i,
  output logic           space_o,
  output logic           valid_o,
  input  logic           ready_i,
  output igmp_pkg::res_t res_o
);

  igmp_pkg::res_t head_q, head_d;
  igmp_pkg::res_t skid_q, skid_d;
  logic           head_v_q, head_v_d;
  logic           skid_v_q, skid_v_d;
  logic           pop;

  assign pop     = head_v_q && ready_i;
  assign space_o = !skid_v_q;
  assign valid_o = head_v_q;
  assign res_o   = head_q;

  // Slot control; a push only arrives while the skid slot is empty
  always_comb begin
    head_d   = head_q;
    skid_d   = skid_q;
    head_v_d = head_v_q;
    skid_v_d = skid_v_q;
    if (skid_v_q) begin
      if (pop) begin
        head_d   = skid_q;
        skid_v_d = 1'b0;
      end
    end else if (!head_v_q || pop) begin
      head_d   = res_i;
      head_v_d = push_i;
    end else if (push_i) begin
      skid_d   = res_i;
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      head_v_q <= head_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

endmodule

// ===== src/igmp_message_parser.sv =====
// Channel  Dir  Word
// in_i     in   data_byte[8], first_byte[1], message_length[16]
// out_o    out  field_kind[4], field_value[32], message_class[3],
//               record_index[16], element_index[16], end_of_message[1]
//
// One byte word is taken every cycle while in_i is ready; the byte that
// completes a field loads its word into the result register, and out_o
// is driven from there. A skid slot behind the result register holds one
// more word; in_i stalls while both hold one, which needs out_o held off.
// Reset (rst_ni low, asynchronous) leaves the parser idle, waiting for a
// first byte, with no word pending.
module igmp_message_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  igmp_in_if.sink    in_i,
  igmp_out_if.source out_o
);

  logic           accept;
  logic           space;
  logic           res_valid;
  igmp_pkg::res_t res;
  igmp_pkg::res_t res_out;

  assign in_i.ready = space;
  assign accept     = in_i.valid && space;

  igmp_parse u_parse (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .data_byte_i     (in_i.data_byte),
    .first_byte_i    (in_i.first_byte),
    .message_length_i(in_i.message_length),
    .res_valid_o     (res_valid),
    .res_o           (res)
  );

  igmp_outbuf u_outbuf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_valid),
    .res_i  (res),
    .space_o(space),
    .valid_o(out_o.valid),
    .ready_i(out_o.ready),
    .res_o  (res_out)
  );

  // Unpack the result word onto the channel
  assign out_o.field_kind     = res_out.kind;
  assign out_o.field_value    = res_out.value;
  assign out_o.message_class  = res_out.cls;
  assign out_o.record_index   = res_out.rec;
  assign out_o.element_index  = res_out.elem;
  assign out_o.end_of_message = res_out.eom;

endmodule
